[design/gcl_pkg.sv]
`default_nettype none

package gcl_pkg;

  // Scanner phases
  localparam logic [2:0] PH_BUF  = 3'd0;
  localparam logic [2:0] PH_HDR  = 3'd1;
  localparam logic [2:0] PH_BODY = 3'd2;
  localparam logic [2:0] PH_SKIP = 3'd3;
  localparam logic [2:0] PH_TEXT = 3'd4;
  localparam logic [2:0] PH_FAIL = 3'd5;

  // Pending GLB faults
  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_CHUNK   = 2'd1;
  localparam logic [1:0] ERR_VERSION = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_VERSION = 2'd2;

  localparam logic [31:0] MAGIC_GLB   = 32'h4654_6C67;
  localparam logic [31:0] CHUNK_JSON  = 32'h4E4F_534A;
  localparam logic [31:0] HDR_TOTAL   = 32'd20;
  localparam logic [31:0] GLB_VERSION = 32'd2;
  localparam logic [31:0] POS_VERSION = 32'd7;
  localparam logic [31:0] POS_LENGTH  = 32'd11;
  localparam logic [31:0] POS_CHUNK   = 32'd15;
  localparam logic [31:0] POS_TYPE    = 32'd19;
  localparam logic [7:0]  BOM_0       = 8'hEF;
  localparam logic [7:0]  BOM_1       = 8'hBB;
  localparam logic [7:0]  BOM_2       = 8'hBF;
  localparam logic [7:0]  OPEN_BRACE  = 8'h7B;

  // Final scanner state of one file, handed to the result logic
  typedef struct packed {
    logic [2:0]  phase;
    logic [1:0]  err;
    logic [31:0] declared;
    logic [31:0] chunk;
    logic [31:0] start;
    logic [31:0] count;
    logic [31:0] size;
  } snap_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        glb_flag;
    logic [31:0] json_offset;
    logic [31:0] text_length;
  } verdict_t;

  // Outcome of running the buffered head bytes through the plain scanner
  typedef struct packed {
    logic [2:0] phase;
    logic [1:0] start;
    logic [2:0] count;
    logic       nul;
  } replay_t;

  function automatic logic is_ws(input logic [7:0] b);
    return (b == 8'h20) || (b >= 8'h09 && b <= 8'h0D);
  endfunction

  // Replay the newest cnt bytes (1 to 4) held in the top of word
  function automatic replay_t plain_replay(input logic [31:0] word, input logic [2:0] cnt);
    replay_t    r;
    logic [7:0] bv [4];
    logic [2:0] idx;
    logic [2:0] first;
    r.phase = PH_SKIP;
    r.start = 2'd0;
    r.count = 3'd0;
    r.nul   = 1'b0;
    // pick the bytes out in file order
    for (int k = 0; k < 4; k++) begin
      idx   = 3'(k) + 3'd4 - cnt;
      bv[k] = word[8 * idx[1:0] +: 8];
    end
    first = (cnt >= 3'd3 && bv[0] == BOM_0 && bv[1] == BOM_1 && bv[2] == BOM_2) ?
            3'd3 : 3'd0;
    for (int k = 0; k < 4; k++) begin
      if (3'(k) < cnt && 3'(k) >= first) begin
        case (r.phase)
          PH_SKIP: begin
            if (!is_ws(bv[k])) begin
              if (bv[k] == OPEN_BRACE) begin
                r.phase = PH_TEXT;
                r.start = 2'(k);
                r.count = 3'd1;
                r.nul   = 1'b0;
              end else begin
                r.phase = PH_FAIL;
              end
            end
          end
          PH_TEXT: begin
            if (!r.nul) begin
              if (bv[k] == 8'h00) r.nul = 1'b1;
              else r.count = r.count + 3'd1;
            end
          end
          default: ;
        endcase
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[design/gcl_in_if.sv]
`default_nettype none

interface gcl_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic [31:0] file_size;
  logic        last;

  modport source (output valid, data_byte, file_size, last, input ready);
  modport sink (input valid, data_byte, file_size, last, output ready);
endinterface

`default_nettype wire

[design/gcl_out_if.sv]
`default_nettype none

interface gcl_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic        glb_flag;
  logic [31:0] json_offset;
  logic [31:0] text_length;

  modport source (output valid, status, glb_flag, json_offset, text_length, input ready);
  modport sink (input valid, status, glb_flag, json_offset, text_length, output ready);
endinterface

`default_nettype wire

[design/gcl_scan.sv]
`default_nettype none

module gcl_scan (
  input  logic          clk,
  input  logic          rst,
  input  logic          take,
  input  logic [7:0]    data_byte,
  input  logic [31:0]   file_size,
  input  logic          last,
  output gcl_pkg::snap_t snap
);
  import gcl_pkg::*;

  logic [31:0] pos, pos_next;
  logic [2:0]  phase, phase_next;
  logic [31:0] hw, hw_next;
  logic [31:0] declared, declared_next;
  logic [31:0] chunk, chunk_next;
  logic [31:0] start, start_next;
  logic [31:0] count, count_next;
  logic        nul, nul_next;
  logic [1:0]  err, err_next;

  logic [31:0] hw_shift;
  logic [2:0]  rep_cnt;
  replay_t     rep;
  logic        use_rep;
  logic [32:0] seen;
  logic [31:0] size;

  assign hw_shift = {data_byte, hw[31:8]};
  assign rep_cnt  = (pos[1:0] == 2'd3) ? 3'd4 : {1'b0, pos[1:0]} + 3'd1;
  assign rep      = plain_replay(hw_shift, rep_cnt);

  // Effective length: bytes seen so far, capped by the stated size
  assign seen = {1'b0, pos} + 33'd1;
  assign size = (seen < {1'b0, file_size}) ? seen[31:0] : file_size;

  // Work out the state after this word
  always_comb begin
    pos_next      = (&pos) ? pos : pos + 32'd1;
    phase_next    = phase;
    hw_next       = hw;
    declared_next = declared;
    chunk_next    = chunk;
    start_next    = start;
    count_next    = count;
    nul_next      = nul;
    err_next      = err;
    use_rep       = 1'b0;
    unique case (phase)
      PH_BUF: begin
        hw_next = hw_shift;
        if (pos[1:0] == 2'd3) begin
          if (hw_shift == MAGIC_GLB) phase_next = PH_HDR;
          else use_rep = 1'b1;
        end else if (last) begin
          use_rep = 1'b1;
        end
      end
      PH_HDR: begin
        hw_next = hw_shift;
        if (pos == POS_VERSION) begin
          if (hw_shift != GLB_VERSION) err_next = ERR_VERSION;
        end else if (pos == POS_LENGTH) begin
          declared_next = hw_shift;
        end else if (pos == POS_CHUNK) begin
          chunk_next = hw_shift;
        end else if (pos >= POS_TYPE) begin
          if (hw_shift != CHUNK_JSON && err == ERR_NONE) err_next = ERR_CHUNK;
          phase_next = PH_BODY;
          count_next = 32'd0;
          nul_next   = 1'b0;
        end
      end
      PH_BODY, PH_TEXT: begin
        if (!nul) begin
          if (data_byte == 8'h00) nul_next = 1'b1;
          else if (!(&count)) count_next = count + 32'd1;
        end
      end
      PH_SKIP: begin
        if (!is_ws(data_byte)) begin
          if (data_byte == OPEN_BRACE) begin
            phase_next = PH_TEXT;
            start_next = pos;
            count_next = 32'd1;
            nul_next   = 1'b0;
          end else begin
            phase_next = PH_FAIL;
          end
        end
      end
      PH_FAIL: ;
      default: ;
    endcase
    // take the replayed head bytes over
    if (use_rep) begin
      phase_next = rep.phase;
      start_next = {30'd0, rep.start};
      count_next = {29'd0, rep.count};
      nul_next   = rep.nul;
    end
  end

  // Advance on each word; on the final word capture the outcome and rearm
  always_ff @(posedge clk) begin
    if (rst) begin
      pos      <= 32'd0;
      phase    <= PH_BUF;
      hw       <= 32'd0;
      declared <= 32'd0;
      chunk    <= 32'd0;
      start    <= 32'd0;
      count    <= 32'd0;
      nul      <= 1'b0;
      err      <= ERR_NONE;
    end else if (take) begin
      if (last) begin
        pos      <= 32'd0;
        phase    <= PH_BUF;
        hw       <= 32'd0;
        declared <= 32'd0;
        chunk    <= 32'd0;
        start    <= 32'd0;
        count    <= 32'd0;
        nul      <= 1'b0;
        err      <= ERR_NONE;
      end else begin
        pos      <= pos_next;
        phase    <= phase_next;
        hw       <= hw_next;
        declared <= declared_next;
        chunk    <= chunk_next;
        start    <= start_next;
        count    <= count_next;
        nul      <= nul_next;
        err      <= err_next;
      end
    end
  end

  // Snapshot of the final state
  always_ff @(posedge clk) begin
    if (take && last) begin
      snap.phase    <= phase_next;
      snap.err      <= err_next;
      snap.declared <= declared_next;
      snap.chunk    <= chunk_next;
      snap.start    <= start_next;
      snap.count    <= count_next;
      snap.size     <= size;
    end
  end

endmodule

`default_nettype wire

[design/gcl_judge.sv]
`default_nettype none

module gcl_judge (
  input  gcl_pkg::snap_t    snap,
  output gcl_pkg::verdict_t verdict
);
  import gcl_pkg::*;

  logic [31:0] room;
  logic [31:0] body_room;

  assign room      = snap.size - snap.start;
  assign body_room = snap.declared - HDR_TOTAL;

  // Check the GLB header fields in order, then clip the text length; plain text is clipped to the bytes left
  always_comb begin
    verdict.status      = ST_OK;
    verdict.glb_flag    = 1'b0;
    verdict.json_offset = 32'd0;
    verdict.text_length = 32'd0;
    if (snap.phase == PH_HDR || snap.phase == PH_BODY) begin
      if (snap.phase == PH_HDR || snap.size < HDR_TOTAL) begin
        verdict.status = ST_INVALID;
      end else if (snap.err == ERR_VERSION) begin
        verdict.status = ST_VERSION;
      end else if (snap.declared > snap.size || snap.declared < HDR_TOTAL) begin
        verdict.status = ST_INVALID;
      end else if (snap.err != ERR_NONE) begin
        verdict.status = ST_INVALID;
      end else if (snap.chunk > body_room) begin
        verdict.status = ST_INVALID;
      end else begin
        verdict.glb_flag    = 1'b1;
        verdict.json_offset = HDR_TOTAL;
        verdict.text_length = (snap.count < snap.chunk) ? snap.count : snap.chunk;
      end
    end else if (snap.phase != PH_TEXT || snap.start >= snap.size) begin
      verdict.status = ST_INVALID;
    end else begin
      verdict.json_offset = snap.start;
      verdict.text_length = (snap.count < room) ? snap.count : room;
    end
  end

endmodule

`default_nettype wire

[design/gltf_container_locator_top.sv]
`default_nettype none

// Locates the JSON text of a glTF file streamed in one byte per word, in file
// order, with last set on the final byte. The block takes one byte every cycle
// while the result stage has room: each byte costs one update of the scanner
// registers, a few compares and a saturating count. One result word is issued
// per file through the result stage (the snapshot register, then the output
// register), which holds up to two finished files, so the input stalls only
// when both are full and the consumer is not taking. After the final byte the
// scanner is back in its reset state and the next byte starts a new file.
module gltf_container_locator_top (
  input  logic clk,
  input  logic rst,
  gcl_in_if.sink    feed,
  gcl_out_if.source result
);
  import gcl_pkg::*;

  logic     take;
  logic     take_last;
  logic     snap_valid;
  logic     snap_move;
  logic     out_valid;
  logic     out_free;
  snap_t    snap;
  verdict_t verdict;
  verdict_t out_word;

  assign out_free   = !out_valid || result.ready;
  assign snap_move  = snap_valid && out_free;
  assign feed.ready = !snap_valid || out_free;
  assign take       = feed.valid && feed.ready;
  assign take_last  = take && feed.last;

  gcl_scan u_scan (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .data_byte (feed.data_byte),
    .file_size (feed.file_size),
    .last      (feed.last),
    .snap      (snap)
  );

  gcl_judge u_judge (
    .snap    (snap),
    .verdict (verdict)
  );

  // Hold the snapshot until the output register frees up
  always_ff @(posedge clk) begin
    if (rst) begin
      snap_valid <= 1'b0;
    end else if (take_last) begin
      snap_valid <= 1'b1;
    end else if (snap_move) begin
      snap_valid <= 1'b0;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (snap_move) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (snap_move) out_word <= verdict;
  end

  assign result.valid       = out_valid;
  assign result.status      = out_word.status;
  assign result.glb_flag    = out_word.glb_flag;
  assign result.json_offset = out_word.json_offset;
  assign result.text_length = out_word.text_length;

  // A final byte always leaves a pending result behind it
  a_last_snaps: assert property (@(posedge clk) disable iff (rst)
    take_last |=> snap_valid)
    else $error("final byte taken without a pending result");

  // A binary result is always a good one starting after the header
  a_binary_ok: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.glb_flag) |->
      (result.status == ST_OK && result.json_offset == HDR_TOTAL))
    else $error("binary result with bad status or offset");

  // A failed file reports nothing but its status
  a_error_clear: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.status != ST_OK) |->
      (!result.glb_flag && result.json_offset == 32'd0 && result.text_length == 32'd0))
    else $error("error result carries text fields");

endmodule

`default_nettype wire
